@@ rtl/hpt_pkg.sv @@
package hpt_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int NUM_REGS    = 8;
   localparam int REG_WIDTH   = 64;
   localparam int INDEX_WIDTH = 4;
   // Accumulator: three floor-shifted products plus a translation term.
   localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
   localparam int ACC_WIDTH   = PROD_WIDTH - FRAC_BITS + 4;
   // Cycles from an accepted item to its result strobe.
   localparam int LATENCY     = COORD_WIDTH + 5;

   typedef logic [NUM_REGS-1:0][REG_WIDTH-1:0] matrix_type;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
   } in_type;

   typedef struct packed {
      logic signed [31:0] qx;
      logic signed [31:0] qy;
      logic signed [31:0] qz;
      logic               w_is_zero;
      logic               clipped;
   } out_type;

   typedef struct packed {
      logic                        valid;
      logic signed [ACC_WIDTH-1:0] num;
      logic signed [ACC_WIDTH-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                   valid;
      logic [COORD_WIDTH-1:0] quot;
      logic                   sat;
      logic                   zero;
   } div_rsp_type;

   // Matrix entry M[r][c]: the signed 32-bit half c % 2 of register r * 2 + c / 2.
   function automatic logic signed [COORD_WIDTH-1:0] entry(input matrix_type m,
                                                           input int r, input int c);
      logic [REG_WIDTH-1:0] word;
      word = m[r * 2 + c / 2];
      return $signed(word[(c % 2) * 32 +: COORD_WIDTH]);
   endfunction

endpackage

@@ rtl/hpt_mac.sv @@
module hpt_mac
   import hpt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  in_type      in_data,
   input  matrix_type  matrix,
   output div_req_type lane_x,
   output div_req_type lane_y,
   output div_req_type lane_z
);

   logic                                  p_valid_ff;
   logic signed [2:0][COORD_WIDTH-1:0]    p_ff;
   logic                                  m_valid_ff;
   logic signed [3:0][2:0][PROD_WIDTH-1:0] prod_ff;
   logic signed [3:0][PROD_WIDTH-1:0]     prod_in [3];
   logic                                  a_valid_ff;
   logic signed [3:0][ACC_WIDTH-1:0]      acc_ff;
   logic signed [3:0][ACC_WIDTH-1:0]      acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= in_valid;
         m_valid_ff <= p_valid_ff;
         a_valid_ff <= m_valid_ff;
      end
      p_ff[0] <= in_data.px[COORD_WIDTH-1:0];
      p_ff[1] <= in_data.py[COORD_WIDTH-1:0];
      p_ff[2] <= in_data.pz[COORD_WIDTH-1:0];
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 3; r++) begin
            prod_ff[c][r] <= prod_in[r][c];
         end
      end
      acc_ff <= acc_in;
   end

   // Elements of a packed array are unsigned, so the sign is restored explicitly.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 4; c++) begin
            prod_in[r][c] = PROD_WIDTH'($signed(p_ff[r])) *
                            PROD_WIDTH'(entry(matrix, r, c));
         end
      end
   end

   // Floor rescale is an arithmetic shift; the translation row is added as is.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         acc_in[c] = ACC_WIDTH'(entry(matrix, 3, c));
         for (int r = 0; r < 3; r++) begin
            acc_in[c] = acc_in[c] + ACC_WIDTH'($signed(prod_ff[c][r]) >>> FRAC_BITS);
         end
      end
   end

   assign lane_x = '{valid: a_valid_ff, num: acc_ff[0], den: acc_ff[3]};
   assign lane_y = '{valid: a_valid_ff, num: acc_ff[1], den: acc_ff[3]};
   assign lane_z = '{valid: a_valid_ff, num: acc_ff[2], den: acc_ff[3]};

endmodule

@@ rtl/hpt_div_lane.sv @@
module hpt_div_lane
   import hpt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int QB = COORD_WIDTH;
   localparam int RW = ACC_WIDTH;

   typedef struct packed {
      logic          valid;
      logic          neg;
      logic          ovf;
      logic          zero;
      logic [RW-1:0] d;
      logic [RW-1:0] r;
      logic [QB-1:0] low;
      logic [QB-1:0] q;
   } step_type;

   step_type    st_ff [QB+1];
   step_type    st_in [QB+1];
   div_rsp_type rsp_ff;
   div_rsp_type rsp_in;

   // Preparation: magnitudes, sign, zero test and check for a quotient over QB bits.
   // After it, one restoring quotient bit per stage.
   always_comb begin
      logic [RW-1:0]    n;
      logic [RW-1:0]    d;
      logic [RW+FRAC_BITS-1:0] big;
      logic [RW:0]      rs;
      logic             ge;
      n = req.num[RW-1] ? RW'(-req.num) : RW'(req.num);
      d = req.den[RW-1] ? RW'(-req.den) : RW'(req.den);
      big = {n, {FRAC_BITS{1'b0}}};
      st_in[0].valid = req.valid;
      st_in[0].neg   = req.num[RW-1] ^ req.den[RW-1];
      st_in[0].zero  = (req.den == '0);
      st_in[0].d     = d;
      st_in[0].ovf   = ((RW+FRAC_BITS)'(big >> QB) >= (RW+FRAC_BITS)'(d));
      st_in[0].r     = RW'(big >> QB);
      st_in[0].low   = big[QB-1:0];
      st_in[0].q     = '0;
      for (int k = 1; k <= QB; k++) begin
         rs = {st_ff[k-1].r, st_ff[k-1].low[QB-1]};
         ge = (rs >= {1'b0, st_ff[k-1].d});
         st_in[k]     = st_ff[k-1];
         st_in[k].r   = ge ? RW'(rs - {1'b0, st_ff[k-1].d}) : RW'(rs);
         st_in[k].low = {st_ff[k-1].low[QB-2:0], 1'b0};
         st_in[k].q   = {st_ff[k-1].q[QB-2:0], ge};
      end
   end

   always_comb begin
      logic [QB:0] limit;
      logic [QB:0] mag;
      logic        sat;
      step_type    f;
      f     = st_ff[QB];
      limit = f.neg ? (QB+1)'(1) << (QB - 1) : ((QB+1)'(1) << (QB - 1)) - 1'b1;
      sat   = f.ovf || ({1'b0, f.q} > limit);
      mag   = sat ? limit : {1'b0, f.q};
      rsp_in.valid = f.valid;
      rsp_in.zero  = f.zero;
      rsp_in.sat   = sat && !f.zero;
      rsp_in.quot  = f.zero ? '0 : (f.neg ? QB'(-mag) : QB'(mag));
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= QB; k++) begin
         if (reset) begin
            st_ff[k] <= '0;
         end else begin
            st_ff[k] <= st_in[k];
         end
      end
      if (reset) begin
         rsp_ff <= '0;
      end else begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

@@ rtl/homogeneous_point_transform.sv @@
// Transforms one signed Q16.16 point (px, py, pz) by a 4x4 matrix in row-vector
// form and divides x, y and z by the resulting w. An item is taken on every
// clock edge where start is high; busy stays low, so a new point may follow in
// every cycle. Each result appears on rsp_data for exactly one cycle, marked by
// rsp_valid, after its item has passed the input register, the products
// register of the twelve multipliers, the column-sum register, a register that
// prepares the division, a pipelined restoring divider (one quotient bit per
// stage) and one output register. The receiver cannot stall the block, so
// it must take every result in the cycle it is shown. A zero w gives zero
// coordinates with w_is_zero set; a quotient outside the signed 32-bit range
// saturates and sets clipped. The matrix is written through the csr port and
// must only be changed while no item is in flight; indexes above seven are
// ignored. After reset the matrix is the identity.
module homogeneous_point_transform
   import hpt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  in_type                 req_data,
   output logic                   rsp_valid,
   output out_type                rsp_data,
   input  logic                   csr_we,
   input  logic [INDEX_WIDTH-1:0] csr_index,
   input  logic [REG_WIDTH-1:0]   csr_wdata
);

   matrix_type  matrix_ff;
   div_req_type lane_x;
   div_req_type lane_y;
   div_req_type lane_z;
   div_rsp_type rsp_x;
   div_rsp_type rsp_y;
   div_rsp_type rsp_z;

   // The pipeline never holds back, so the block is always ready.
   assign busy = 1'b0;

   // Matrix registers; reset gives the identity in Q16.16.
   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff <= {REG_WIDTH'(1) << (FRAC_BITS + 32), REG_WIDTH'(0),
                       REG_WIDTH'(1) << FRAC_BITS, REG_WIDTH'(0),
                       REG_WIDTH'(0), REG_WIDTH'(1) << (FRAC_BITS + 32),
                       REG_WIDTH'(0), REG_WIDTH'(1) << FRAC_BITS};
      end else if (csr_we && (csr_index < INDEX_WIDTH'(NUM_REGS))) begin
         matrix_ff[csr_index[2:0]] <= csr_wdata;
      end
   end

   hpt_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .in_data  (req_data),
      .matrix   (matrix_ff),
      .lane_x   (lane_x),
      .lane_y   (lane_y),
      .lane_z   (lane_z)
   );

   // Three identical divider lanes share the same w and stay in lockstep.
   hpt_div_lane u_div_x (.clock(clock), .reset(reset), .req(lane_x), .rsp(rsp_x));
   hpt_div_lane u_div_y (.clock(clock), .reset(reset), .req(lane_y), .rsp(rsp_y));
   hpt_div_lane u_div_z (.clock(clock), .reset(reset), .req(lane_z), .rsp(rsp_z));

   assign rsp_valid          = rsp_x.valid;
   assign rsp_data.qx        = $signed(rsp_x.quot);
   assign rsp_data.qy        = $signed(rsp_y.quot);
   assign rsp_data.qz        = $signed(rsp_z.quot);
   assign rsp_data.w_is_zero = rsp_x.zero;
   assign rsp_data.clipped   = rsp_x.sat || rsp_y.sat || rsp_z.sat;

endmodule

@@ rtl/hpt_checker.sv @@
module hpt_port_checker
   import hpt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  logic    rsp_valid,
   input  out_type rsp_data
);

   // Every accepted item produces its result a fixed time later.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("result missing after accepted item");

   // A zero w zeroes all coordinates and never reports saturation.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.w_is_zero) |->
         (rsp_data.qx == 0 && rsp_data.qy == 0 && rsp_data.qz == 0 && !rsp_data.clipped))
      else $error("zero w result not cleared");

   // Reset flushes every item in flight.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe after reset");

endmodule

bind homogeneous_point_transform hpt_port_checker u_hpt_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
